// ===== rtl/lruc_pkg.sv =====
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants for the 8-way counter-based LRU rank update.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int unsigned SET_W  = 10;
  localparam int unsigned SETS   = 1 << SET_W;
  localparam int unsigned WAYS   = 8;
  localparam int unsigned WAY_W  = 3;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned ROW_W  = WAYS * RANK_W;

  typedef logic signed [RANK_W-1:0] rank_t;
  typedef rank_t [WAYS-1:0]         rank_row_t;

  localparam rank_t     RANK_EMPTY = rank_t'(-1);
  localparam rank_t     RANK_ONE   = rank_t'(1);
  localparam rank_t     RANK_MRU   = rank_t'(WAYS - 1);
  localparam rank_row_t ROW_EMPTY  = {WAYS{RANK_EMPTY}};

  typedef enum logic [1:0] {
    CASE_MRU  = 2'd0,
    CASE_HIT  = 2'd1,
    CASE_FILL = 2'd2
  } update_case_e;

  // write request into the rank store
  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] addr;
    rank_row_t        data;
  } wr_req_t;

endpackage

// ===== rtl/lruc_store.sv =====
// ----------------------------------------------------------------------------
// lruc_store
// Rank store: one row of all way ranks per set, registered synchronous read,
// one write port, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module lruc_store import lruc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_addr_i,
  output rank_row_t        rd_data_o,
  input  wr_req_t          wr_req_i,
  output logic             init_done_o
);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_data_q;

  logic [SET_W-1:0] clr_addr_q, clr_addr_d;
  logic             init_done_q, init_done_d;

  logic             we;
  logic [SET_W-1:0] waddr;
  logic [ROW_W-1:0] wdata;

  // sweep owns the write port until every row is empty
  always_comb begin
    clr_addr_d  = clr_addr_q;
    init_done_d = init_done_q;
    if (!init_done_q) begin
      clr_addr_d = clr_addr_q + SET_W'(1);
      if (clr_addr_q == SET_W'(SETS - 1)) begin
        init_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      init_done_q <= 1'b0;
    end else begin
      clr_addr_q  <= clr_addr_d;
      init_done_q <= init_done_d;
    end
  end

  assign we    = init_done_q ? wr_req_i.en   : 1'b1;
  assign waddr = init_done_q ? wr_req_i.addr : clr_addr_q;
  assign wdata = init_done_q ? ROW_W'(wr_req_i.data) : ROW_W'(ROW_EMPTY);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o   = rank_row_t'(rd_data_q);
  assign init_done_o = init_done_q;

endmodule

// ===== rtl/lruc_update.sv =====
// ----------------------------------------------------------------------------
// lruc_update
// Rank modify step: new ranks of one set for an access to one way.
// ----------------------------------------------------------------------------
module lruc_update import lruc_pkg::*; (
  input  rank_row_t        row_i,
  input  logic [WAY_W-1:0] way_i,
  output rank_row_t        row_o,
  output update_case_e     case_o
);

  rank_t r;

  always_comb begin
    r      = row_i[way_i];
    row_o  = row_i;
    case_o = CASE_MRU;
    if (r == RANK_MRU) begin
      case_o = CASE_MRU;
    end else if (!r[RANK_W-1]) begin
      // hit: everything more recent than the way slides down one
      for (int i = 0; i < WAYS; i++) begin
        if ($signed(row_i[i]) > $signed(r)) begin
          row_o[i] = row_i[i] - RANK_ONE;
        end
      end
      row_o[way_i] = RANK_MRU;
      case_o       = CASE_HIT;
    end else begin
      // fill: lower-numbered ways age, saturating at empty
      for (int i = 0; i < WAYS; i++) begin
        if ((WAY_W'(i) < way_i) && !row_i[i][RANK_W-1]) begin
          row_o[i] = row_i[i] - RANK_ONE;
        end
      end
      row_o[way_i] = RANK_MRU;
      case_o       = CASE_FILL;
    end
  end

endmodule

// ===== rtl/lru_counter_update_8way.sv =====
// ----------------------------------------------------------------------------
// lru_counter_update_8way
// Counter-based LRU rank keeper for an 8-way cache with 1024 sets.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (set_index_i, way_index_i) is taken on a rising edge with
//    start_i high and busy_o low. One result comes back per request.
//  - Result: update_case_o and rank_way0_o..rank_way7_o, shown for exactly
//    one cycle with done_o high. The receiver cannot stall; it must take
//    the result in that cycle.
//  - Pipeline: a taken request reads the store into the modify stage
//    (s2), whose updated row is registered into the result stage.
//  - Throughput: one request per cycle once busy_o is low. The rank
//    store is read on accept and written back in the next cycle; a
//    request to the set written on that edge uses the forward register.
//  - Reset: rst_ni clears control state, then a clearing sweep writes
//    every set to empty (-1), one set per cycle, with busy_o high
//    throughout. After the sweep busy_o stays low.
// ----------------------------------------------------------------------------
module lru_counter_update_8way import lruc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [SET_W-1:0]        set_index_i,
  input  logic [WAY_W-1:0]        way_index_i,
  output logic                    done_o,
  output logic [1:0]              update_case_o,
  output logic signed [RANK_W-1:0] rank_way0_o,
  output logic signed [RANK_W-1:0] rank_way1_o,
  output logic signed [RANK_W-1:0] rank_way2_o,
  output logic signed [RANK_W-1:0] rank_way3_o,
  output logic signed [RANK_W-1:0] rank_way4_o,
  output logic signed [RANK_W-1:0] rank_way5_o,
  output logic signed [RANK_W-1:0] rank_way6_o,
  output logic signed [RANK_W-1:0] rank_way7_o
);

  logic         init_done;
  logic         accept;

  // modify stage (row data arrives from the store this cycle)
  logic             s2_vld_q;
  logic [SET_W-1:0] s2_set_q;
  logic [WAY_W-1:0] s2_way_q;

  // last row written, covers the read issued on the same edge
  logic             fwd_vld_q;
  logic [SET_W-1:0] fwd_set_q;
  rank_row_t        fwd_row_q;

  // result stage
  logic             done_q;
  update_case_e     out_case_q;
  rank_row_t        out_row_q;
  logic [WAY_W-1:0] out_way_q;

  rank_row_t    rd_row;
  rank_row_t    cur_row;
  rank_row_t    new_row;
  update_case_e new_case;
  wr_req_t      wr_req;

  assign busy_o = !init_done;
  assign accept = start_i && init_done;

  lruc_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (set_index_i),
    .rd_data_o   (rd_row),
    .wr_req_i    (wr_req),
    .init_done_o (init_done)
  );

  // read data misses the write made on the edge it was sampled
  assign cur_row = (fwd_vld_q && (fwd_set_q == s2_set_q)) ? fwd_row_q : rd_row;

  lruc_update u_update (
    .row_i  (cur_row),
    .way_i  (s2_way_q),
    .row_o  (new_row),
    .case_o (new_case)
  );

  assign wr_req.en   = s2_vld_q;
  assign wr_req.addr = s2_set_q;
  assign wr_req.data = new_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      s2_vld_q <= accept;
      done_q   <= s2_vld_q;
      if (s2_vld_q) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_set_q <= set_index_i;
      s2_way_q <= way_index_i;
    end
    if (s2_vld_q) begin
      fwd_set_q  <= s2_set_q;
      fwd_row_q  <= new_row;
      out_case_q <= new_case;
      out_row_q  <= new_row;
      out_way_q  <= s2_way_q;
    end
  end

  assign done_o        = done_q;
  assign update_case_o = out_case_q;
  assign rank_way0_o   = out_row_q[0];
  assign rank_way1_o   = out_row_q[1];
  assign rank_way2_o   = out_row_q[2];
  assign rank_way3_o   = out_row_q[3];
  assign rank_way4_o   = out_row_q[4];
  assign rank_way5_o   = out_row_q[5];
  assign rank_way6_o   = out_row_q[6];
  assign rank_way7_o   = out_row_q[7];

  // each result traces back to an accepted request, through the modify stage
  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without a request");

  // the clearing sweep runs once
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose after the clearing sweep");

  // the accessed way always ends up most recent
  a_way_is_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_row_q[out_way_q] == RANK_MRU))
    else $error("accessed way not most recent");

  // no request in flight while the sweep owns the store
  a_no_work_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (!s2_vld_q && !done_o))
    else $error("request in flight during clearing sweep");

endmodule
